// File: hw/rtl/ftsw_pkg.sv
package ftsw_pkg;

  // Default width of the byte counter and of every stored offset
  localparam int unsigned OffsetBitsDefault = 24;

  // Type table geometry; the top slot holds the offset of the last header
  localparam int unsigned TypeSlots = 128;
  localparam int unsigned TypeIdxW  = 7;
  localparam logic [TypeIdxW-1:0] EndType = 7'd127;
  localparam logic [7:0]          EndTypeByte = 8'd127;

  // Width of the table length register and of the reported offset
  localparam int unsigned CfgW    = 24;
  localparam int unsigned OutOffW = 24;

  // Configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        RegTableLength = 1'b0;

  // Entries of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Stream widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 64;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_FEED    = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_END    = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  // Reported status
  typedef enum logic [2:0] {
    ST_PARSING = 3'd0,
    ST_MARKER  = 3'd1,
    ST_MISSING = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  // Reason the walk stopped
  typedef enum logic [1:0] {
    FIN_NONE   = 2'd0,
    FIN_MARKER = 2'd1,
    FIN_LAST   = 2'd2,
    FIN_TRUNC  = 2'd3
  } finish_e;

  // Walker phases
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_FORMATTED = 3'd1,
    PH_STRINGS   = 3'd2,
    PH_PAD       = 3'd3,
    PH_IDLE      = 3'd4
  } walk_phase_e;

  // One classified item as it travels from front to back
  typedef struct packed {
    op_e                 op;
    logic [7:0]          data_byte;
    logic [TypeIdxW-1:0] type_index;
  } item_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
  } queue_stat_t;

endpackage

// File: hw/rtl/firmware_table_structure_walker.sv
// Firmware structure table walker. Table bytes, type lookups and restarts
// enter on the slave stream, one item per clock cycle when the result side
// keeps up; a two-entry queue parts the input side from the walker so either
// side may stall on its own. A result passes through the queue register and
// then the result register; a lookup's offset comes from the type table's
// registered read port, loaded together with the result register. Each
// complete header yields a header report, a walk that runs into the table
// end an end-of-data report, and each lookup an answer; other items yield
// nothing. Restart clears the type table at once through per-slot valid bits,
// with no clearing pass. Program table_length over the register port before
// the first byte of a table.
module firmware_table_structure_walker #(
  parameter int unsigned OFFSET_BITS = ftsw_pkg::OffsetBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ftsw_pkg::InDataW-1:0]  s_axis_tdata,   // data_byte[7:0], type_index[14:8]
  input  logic [1:0]                    s_axis_tuser,   // operation[1:0]
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // struct_type[7:0], struct_handle[23:8], struct_offset[47:24],
  // formatted_length[55:48], first_of_type[56], entry_found[57], parse_status[60:58]
  output logic [ftsw_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,   // kind[1:0]
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftsw_pkg::CfgAddrW-1:0] paddr,
  input  logic [ftsw_pkg::CfgDataW-1:0] pwdata,
  output logic [ftsw_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  logic                  push, q_valid, q_pop;
  ftsw_pkg::item_t       push_item, q_item;
  ftsw_pkg::queue_stat_t q_stat;
  logic [OFFSET_BITS-1:0] len;

  ftsw_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push_o        (push),
    .push_item_o   (push_item),
    .stat_i        (q_stat),
    .len_o         (len)
  );

  ftsw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .stat_o      (q_stat),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  ftsw_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .len_i         (len),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: hw/rtl/ftsw_ram.sv
module ftsw_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ftsw_queue.sv
module ftsw_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ftsw_pkg::item_t        push_item_i,
  output ftsw_pkg::queue_stat_t  stat_o,
  output logic                   valid_o,
  output ftsw_pkg::item_t        item_o,
  input  logic                   pop_i
);

  localparam int unsigned Depth = ftsw_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ftsw_pkg::item_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full = (count_q == CntW'(Depth));
  assign valid_o     = (count_q != '0);
  assign item_o      = entry_q[rd_ptr_q];
  assign do_push     = push_i && !stat_o.full;
  assign do_pop      = pop_i && valid_o;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: hw/rtl/ftsw_front.sv
module ftsw_front #(
  parameter int unsigned OFFSET_BITS = ftsw_pkg::OffsetBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ftsw_pkg::InDataW-1:0]  s_axis_tdata,  // data_byte, type_index, pad
  input  logic [1:0]                    s_axis_tuser,  // operation
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftsw_pkg::CfgAddrW-1:0] paddr,
  input  logic [ftsw_pkg::CfgDataW-1:0] pwdata,
  output logic [ftsw_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  // Toward queue and back
  output logic                          push_o,
  output ftsw_pkg::item_t               push_item_o,
  input  ftsw_pkg::queue_stat_t         stat_i,
  output logic [OFFSET_BITS-1:0]        len_o
);

  localparam int unsigned CfgW = ftsw_pkg::CfgW;
  localparam int unsigned LenW = (OFFSET_BITS > CfgW) ? OFFSET_BITS : CfgW;

  logic [CfgW-1:0] table_length_q;
  logic            cfg_wr;
  logic [LenW-1:0] len_ext, len_max;
  logic            keep;

  // Register access; the register index sits above the byte lanes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ftsw_pkg::RegTableLength);
  assign prdata = (paddr[2] == ftsw_pkg::RegTableLength)
                ? ftsw_pkg::CfgDataW'(table_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= CfgW'(1);
    end else if (cfg_wr) begin
      table_length_q <= pwdata[CfgW-1:0];
    end
  end

  // Saturate the table length to the largest offset
  assign len_ext = LenW'(table_length_q);
  assign len_max = LenW'({OFFSET_BITS{1'b1}});
  assign len_o   = (len_ext > len_max) ? OFFSET_BITS'(len_max) : OFFSET_BITS'(len_ext);

  // Classify the item; drop undefined operations here
  always_comb begin
    keep                   = 1'b1;
    push_item_o.op         = ftsw_pkg::OP_FEED;
    push_item_o.data_byte  = s_axis_tdata[7:0];
    push_item_o.type_index = s_axis_tdata[8 +: ftsw_pkg::TypeIdxW];
    unique case (s_axis_tuser)
      ftsw_pkg::OP_FEED:    push_item_o.op = ftsw_pkg::OP_FEED;
      ftsw_pkg::OP_LOOKUP:  push_item_o.op = ftsw_pkg::OP_LOOKUP;
      ftsw_pkg::OP_RESTART: push_item_o.op = ftsw_pkg::OP_RESTART;
      default:              keep = 1'b0;
    endcase
  end

  assign s_axis_tready = !stat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready && keep;

endmodule

// File: hw/rtl/ftsw_back.sv
module ftsw_back #(
  parameter int unsigned OFFSET_BITS = ftsw_pkg::OffsetBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // From queue
  input  logic                          q_valid_i,
  input  ftsw_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  input  logic [OFFSET_BITS-1:0]        len_i,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // type, handle, offset, formatted_length, first_of_type, entry_found,
  // parse_status, pad
  output logic [ftsw_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser   // kind
);

  localparam int unsigned OW   = OFFSET_BITS;
  localparam int unsigned OffW = ftsw_pkg::OutOffW;
  localparam int unsigned IdxW = ftsw_pkg::TypeIdxW;

  // Walker state
  ftsw_pkg::walk_phase_e     phase_q, phase_d;
  ftsw_pkg::finish_e         finished_q, finished_d;
  logic [OW-1:0]             byte_count_q, byte_count_d;
  logic [OW-1:0]             header_start_q, header_start_d;
  logic [OW-1:0]             area_end_q, area_end_d;
  logic [OW-1:0]             last_hdr_q, last_hdr_d;
  logic [7:0]                cur_type_q, cur_type_d;
  logic [7:0]                cur_len_q, cur_len_d;
  logic [7:0]                handle_lo_q, handle_lo_d;
  logic [1:0]                hdr_idx_q, hdr_idx_d;
  logic                      str_first_q, str_first_d;
  logic                      prev_zero_q, prev_zero_d;
  logic                      any_hdr_q, any_hdr_d;
  logic [ftsw_pkg::TypeSlots-1:0] type_valid_q, type_valid_d;

  // Result register
  logic                      out_valid_q, out_valid_d;
  ftsw_pkg::kind_e           kind_q;
  logic [7:0]                type_q, flen_q;
  logic [15:0]               handle_q;
  logic [OffW-1:0]           offset_q;
  logic                      first_q, found_q;
  ftsw_pkg::status_e         status_q;

  // Events of this cycle
  logic                      fire, feed_ev, look_ev, rst_ev, byte_live, walk_ev;
  logic                      past_end, last_byte, near_end, trunc, short_len;
  logic                      hdr_ev, end_ev, first_hit, res_ev;
  logic [OW:0]               next_pos_w, area_sum;
  logic [OW-1:0]             next_pos;
  logic [7:0]                eff, b;
  ftsw_pkg::finish_e         fin_hdr;
  ftsw_pkg::status_e         cur_status;

  // Type table
  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr;
  logic [OW-1:0]             ram_wdata, ram_rdata;

  // Take an item when the result register is free or being drained
  assign fire    = q_valid_i && (!out_valid_q || m_axis_tready);
  assign q_pop_o = fire;
  assign feed_ev = fire && (q_item_i.op == ftsw_pkg::OP_FEED);
  assign look_ev = fire && (q_item_i.op == ftsw_pkg::OP_LOOKUP);
  assign rst_ev  = fire && (q_item_i.op == ftsw_pkg::OP_RESTART);
  assign b       = q_item_i.data_byte;

  // Shared position arithmetic
  assign byte_live  = feed_ev && (finished_q == ftsw_pkg::FIN_NONE);
  assign past_end   = (byte_count_q >= len_i);
  assign walk_ev    = byte_live && !past_end;
  assign next_pos_w = {1'b0, byte_count_q} + (OW+1)'(1);
  assign next_pos   = next_pos_w[OW-1:0];
  assign last_byte  = (next_pos_w == {1'b0, len_i});
  assign near_end   = (({1'b0, header_start_q} + (OW+1)'(4)) >= {1'b0, len_i});

  // Header checks; a length below four walks as four
  assign short_len = (cur_len_q <= 8'd4);
  assign eff       = short_len ? 8'd4 : cur_len_q;
  assign area_sum  = {1'b0, header_start_q} + (OW+1)'(eff);
  assign trunc     = (area_sum > {1'b0, len_i});
  assign hdr_ev    = walk_ev && (phase_q == ftsw_pkg::PH_HEADER) && (hdr_idx_q == 2'd3);
  assign fin_hdr   = trunc ? ftsw_pkg::FIN_TRUNC
                   : (cur_type_q == ftsw_pkg::EndTypeByte) ? ftsw_pkg::FIN_MARKER
                   : ftsw_pkg::FIN_NONE;
  assign first_hit = !trunc && !cur_type_q[7] && (cur_type_q != ftsw_pkg::EndTypeByte)
                   && !type_valid_q[cur_type_q[IdxW-1:0]];
  assign end_ev    = byte_live && (past_end || (!hdr_ev && last_byte));
  assign res_ev    = hdr_ev || end_ev || look_ev;

  assign cur_status = ((finished_q == ftsw_pkg::FIN_LAST) && !any_hdr_q)
                    ? ftsw_pkg::ST_EMPTY : ftsw_pkg::status_e'({1'b0, finished_q});

  // Next walker phase
  always_comb begin
    phase_d = phase_q;
    if (rst_ev) begin
      phase_d = ftsw_pkg::PH_HEADER;
    end else if (walk_ev) begin
      unique case (phase_q)
        ftsw_pkg::PH_HEADER: begin
          if ((hdr_idx_q == 2'd0) && near_end) begin
            phase_d = ftsw_pkg::PH_IDLE;
          end else if ((hdr_idx_q == 2'd3) && (fin_hdr == ftsw_pkg::FIN_NONE)) begin
            phase_d = short_len ? ftsw_pkg::PH_STRINGS : ftsw_pkg::PH_FORMATTED;
          end
        end
        ftsw_pkg::PH_FORMATTED: begin
          if (next_pos == area_end_q) phase_d = ftsw_pkg::PH_STRINGS;
        end
        ftsw_pkg::PH_STRINGS: begin
          if (str_first_q) begin
            if (b == 8'd0) phase_d = ftsw_pkg::PH_PAD;
          end else if ((b == 8'd0) && prev_zero_q) begin
            phase_d = ftsw_pkg::PH_HEADER;
          end
        end
        ftsw_pkg::PH_PAD:  phase_d = ftsw_pkg::PH_HEADER;
        ftsw_pkg::PH_IDLE: phase_d = ftsw_pkg::PH_IDLE;
        default:           phase_d = phase_q;
      endcase
    end
  end

  // Walker datapath and table updates
  always_comb begin
    finished_d     = finished_q;
    byte_count_d   = byte_count_q;
    header_start_d = header_start_q;
    area_end_d     = area_end_q;
    last_hdr_d     = last_hdr_q;
    cur_type_d     = cur_type_q;
    cur_len_d      = cur_len_q;
    handle_lo_d    = handle_lo_q;
    hdr_idx_d      = hdr_idx_q;
    str_first_d    = str_first_q;
    prev_zero_d    = prev_zero_q;
    any_hdr_d      = any_hdr_q;
    type_valid_d   = type_valid_q;
    if (rst_ev) begin
      finished_d     = ftsw_pkg::FIN_NONE;
      byte_count_d   = '0;
      header_start_d = '0;
      area_end_d     = '0;
      last_hdr_d     = '0;
      cur_type_d     = '0;
      cur_len_d      = '0;
      handle_lo_d    = '0;
      hdr_idx_d      = '0;
      str_first_d    = 1'b1;
      prev_zero_d    = 1'b0;
      any_hdr_d      = 1'b0;
      type_valid_d   = '0;
    end else begin
      if (walk_ev) begin
        byte_count_d = next_pos;
        unique case (phase_q)
          ftsw_pkg::PH_HEADER: begin
            unique case (hdr_idx_q)
              2'd0: begin
                if (!near_end) begin
                  cur_type_d = b;
                  hdr_idx_d  = 2'd1;
                end
              end
              2'd1: begin
                cur_len_d = b;
                hdr_idx_d = 2'd2;
              end
              2'd2: begin
                handle_lo_d = b;
                hdr_idx_d   = 2'd3;
              end
              default: begin
                hdr_idx_d  = 2'd0;
                any_hdr_d  = 1'b1;
                last_hdr_d = header_start_q;
                finished_d = fin_hdr;
                if (first_hit) type_valid_d[cur_type_q[IdxW-1:0]] = 1'b1;
                if (fin_hdr != ftsw_pkg::FIN_NONE) type_valid_d[ftsw_pkg::EndType] = 1'b1;
                if (fin_hdr == ftsw_pkg::FIN_NONE) begin
                  if (short_len) begin
                    str_first_d = 1'b1;
                    prev_zero_d = 1'b0;
                  end else begin
                    area_end_d = area_sum[OW-1:0];
                  end
                end
              end
            endcase
          end
          ftsw_pkg::PH_FORMATTED: begin
            if (next_pos == area_end_q) begin
              str_first_d = 1'b1;
              prev_zero_d = 1'b0;
            end
          end
          ftsw_pkg::PH_STRINGS: begin
            if (str_first_q) begin
              str_first_d = 1'b0;
              if (b != 8'd0) prev_zero_d = 1'b0;
            end else if ((b == 8'd0) && prev_zero_q) begin
              header_start_d = next_pos;
              hdr_idx_d      = 2'd0;
            end else begin
              prev_zero_d = (b == 8'd0);
            end
          end
          ftsw_pkg::PH_PAD: begin
            header_start_d = next_pos;
            hdr_idx_d      = 2'd0;
          end
          default: begin
          end
        endcase
      end
      // Close the walk at the table end
      if (end_ev) begin
        finished_d = ftsw_pkg::FIN_LAST;
        if (any_hdr_q) type_valid_d[ftsw_pkg::EndType] = 1'b1;
      end
    end
  end

  // One table write per item at most
  assign ram_we    = (hdr_ev && (first_hit || (fin_hdr != ftsw_pkg::FIN_NONE)))
                  || (end_ev && any_hdr_q);
  assign ram_waddr = (hdr_ev && first_hit) ? cur_type_q[IdxW-1:0] : ftsw_pkg::EndType;
  assign ram_wdata = hdr_ev ? header_start_q : last_hdr_q;

  ftsw_ram #(
    .WIDTH (OW),
    .DEPTH (ftsw_pkg::TypeSlots)
  ) u_type_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (look_ev),
    .raddr_i (q_item_i.type_index),
    .rdata_o (ram_rdata)
  );

  // Result valid: set on a new result, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ev) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= ftsw_pkg::PH_HEADER;
      finished_q     <= ftsw_pkg::FIN_NONE;
      byte_count_q   <= '0;
      header_start_q <= '0;
      area_end_q     <= '0;
      last_hdr_q     <= '0;
      cur_type_q     <= '0;
      cur_len_q      <= '0;
      handle_lo_q    <= '0;
      hdr_idx_q      <= '0;
      str_first_q    <= 1'b1;
      prev_zero_q    <= 1'b0;
      any_hdr_q      <= 1'b0;
      type_valid_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      finished_q     <= finished_d;
      byte_count_q   <= byte_count_d;
      header_start_q <= header_start_d;
      area_end_q     <= area_end_d;
      last_hdr_q     <= last_hdr_d;
      cur_type_q     <= cur_type_d;
      cur_len_q      <= cur_len_d;
      handle_lo_q    <= handle_lo_d;
      hdr_idx_q      <= hdr_idx_d;
      str_first_q    <= str_first_d;
      prev_zero_q    <= prev_zero_d;
      any_hdr_q      <= any_hdr_d;
      type_valid_q   <= type_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Load the result payload; lookup offsets come from the table read port
  always_ff @(posedge clk_i) begin
    if (res_ev) begin
      kind_q   <= ftsw_pkg::KIND_LOOKUP;
      type_q   <= '0;
      handle_q <= '0;
      offset_q <= '0;
      flen_q   <= '0;
      first_q  <= 1'b0;
      found_q  <= 1'b0;
      status_q <= cur_status;
      if (hdr_ev) begin
        kind_q   <= ftsw_pkg::KIND_HEADER;
        type_q   <= cur_type_q;
        handle_q <= {b, handle_lo_q};
        offset_q <= OffW'(header_start_q);
        flen_q   <= cur_len_q;
        first_q  <= first_hit;
        status_q <= ftsw_pkg::status_e'({1'b0, fin_hdr});
      end else if (end_ev) begin
        kind_q   <= ftsw_pkg::KIND_END;
        offset_q <= OffW'(last_hdr_q);
        status_q <= any_hdr_q ? ftsw_pkg::ST_MISSING : ftsw_pkg::ST_EMPTY;
      end else begin
        found_q  <= type_valid_q[q_item_i.type_index];
      end
    end
  end

  logic [OffW-1:0] offset_out;
  assign offset_out = (kind_q == ftsw_pkg::KIND_LOOKUP)
                    ? (found_q ? OffW'(ram_rdata) : '0) : offset_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {3'b000, status_q, found_q, first_q, flen_q,
                          offset_out, handle_q, type_q};

  // A finished walk stays finished until a restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finished_q != ftsw_pkg::FIN_NONE) && !rst_ev |=> (finished_q != ftsw_pkg::FIN_NONE))
    else $error("walk left finished state without restart");

  // The table write port never meets a lookup read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && look_ev))
    else $error("table write and lookup in the same cycle");

  // Header byte index only advances inside the header phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_idx_q != 2'd0) |-> (phase_q == ftsw_pkg::PH_HEADER))
    else $error("header index set outside header phase");

  // The end slot is recorded only once some header was seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    type_valid_q[ftsw_pkg::EndType] |-> any_hdr_q)
    else $error("end slot recorded without any header");

endmodule

// File: test/tb.sv
module tb;

  // Reserved operation code, ignored by the walker
  localparam logic [1:0] OpReserved = 2'd3;
  // Register address of table_length
  localparam logic [ftsw_pkg::CfgAddrW-1:0] TableLengthAddr =
    {ftsw_pkg::RegTableLength, 2'b00};
  localparam int unsigned OffMask = 32'h00FF_FFFF;
  localparam logic [23:0] MaxTableLength = 24'hFF_FFFF;
  // Cycles to let in-flight items without a result settle before a register write
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    ftsw_pkg::kind_e   kind;
    logic [7:0]        stype;
    logic [15:0]       handle;
    logic [23:0]       offset;
    logic [7:0]        flen;
    logic              first_hit;
    logic              found;
    ftsw_pkg::status_e status;
  } walk_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [ftsw_pkg::InDataW-1:0] s_axis_tdata;   // data_byte[7:0], type_index[14:8]
  logic [1:0] s_axis_tuser;                     // operation[1:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // struct_type[7:0], struct_handle[23:8], struct_offset[47:24],
  // formatted_length[55:48], first_of_type[56], entry_found[57], parse_status[60:58]
  logic [ftsw_pkg::OutDataW-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;                     // kind[1:0]
  logic psel;
  logic penable;
  logic pwrite;
  logic [ftsw_pkg::CfgAddrW-1:0] paddr;
  logic [ftsw_pkg::CfgDataW-1:0] pwdata;
  logic [ftsw_pkg::CfgDataW-1:0] prdata;
  logic pready;

  firmware_table_structure_walker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walker state as predicted
  logic [23:0]           tbl_len;
  logic [23:0]           byte_pos;
  ftsw_pkg::walk_phase_e phase;
  logic [23:0]           hdr_start;
  logic [23:0]           area_end;
  logic [7:0]            cur_type;
  logic [7:0]            cur_len;
  logic [15:0]           cur_handle;
  bit                    str_first;
  bit                    prev_zero;
  bit                    seen_hdr;
  logic [23:0]           last_hdr;
  ftsw_pkg::finish_e     fin;
  bit                    slot_valid [ftsw_pkg::TypeSlots];
  logic [23:0]           slot_off [ftsw_pkg::TypeSlots];
  // Slots written at least once since reset; only these are looked up
  bit                    slot_ever [ftsw_pkg::TypeSlots];

  walk_result_t pending_reports[$];
  logic [7:0]   table_image[$];
  int unsigned  items_sent;
  int unsigned  mismatch_count;
  int unsigned  src_idle_pct;
  int unsigned  snk_stall_pct;
  int unsigned  idle_cycles;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void clear_walk();
    byte_pos   = '0;
    phase      = ftsw_pkg::PH_HEADER;
    hdr_start  = '0;
    area_end   = '0;
    cur_type   = '0;
    cur_len    = '0;
    cur_handle = '0;
    str_first  = 1'b1;
    prev_zero  = 1'b0;
    seen_hdr   = 1'b0;
    last_hdr   = '0;
    fin        = ftsw_pkg::FIN_NONE;
    for (int k = 0; k < ftsw_pkg::TypeSlots; k++) begin
      slot_valid[k] = 1'b0;
      slot_off[k]   = '0;
    end
  endfunction

  function automatic ftsw_pkg::status_e walk_status();
    case (fin)
      ftsw_pkg::FIN_NONE:   return ftsw_pkg::ST_PARSING;
      ftsw_pkg::FIN_MARKER: return ftsw_pkg::ST_MARKER;
      ftsw_pkg::FIN_LAST:   return seen_hdr ? ftsw_pkg::ST_MISSING : ftsw_pkg::ST_EMPTY;
      default:              return ftsw_pkg::ST_TRUNC;
    endcase
  endfunction

  // Store the last header offset under the end type once any header was seen
  function automatic void record_end();
    if (seen_hdr) begin
      slot_valid[ftsw_pkg::EndType] = 1'b1;
      slot_off[ftsw_pkg::EndType]   = last_hdr;
      slot_ever[ftsw_pkg::EndType]  = 1'b1;
    end
  endfunction

  function automatic void end_walk(output walk_result_t r);
    fin = ftsw_pkg::FIN_LAST;
    record_end();
    r = '0;
    r.kind   = ftsw_pkg::KIND_END;
    r.offset = last_hdr;
    r.status = walk_status();
  endfunction

  // Advance the predicted walker by one accepted transaction
  function automatic void walk_step(input logic [1:0] op, input logic [7:0] b,
                                    input logic [6:0] idx, output bit has,
                                    output walk_result_t r);
    int unsigned len;
    int unsigned pos;
    int unsigned i;
    int unsigned eff;
    bit hit;
    r   = '0;
    has = 1'b0;
    if (op == ftsw_pkg::OP_RESTART) begin
      clear_walk();
      return;
    end
    if (op == ftsw_pkg::OP_LOOKUP) begin
      r.kind = ftsw_pkg::KIND_LOOKUP;
      if (slot_valid[idx]) begin
        r.offset = slot_off[idx];
        r.found  = 1'b1;
      end
      r.status = walk_status();
      has = 1'b1;
      return;
    end
    if (op != ftsw_pkg::OP_FEED || fin != ftsw_pkg::FIN_NONE) return;

    len = tbl_len;
    pos = byte_pos;
    if (pos >= len) begin
      end_walk(r);
      has = 1'b1;
      return;
    end

    case (phase)
      ftsw_pkg::PH_HEADER: begin
        i = (pos - hdr_start) & OffMask;
        if (i == 0) begin
          if (hdr_start + 4 >= len) phase = ftsw_pkg::PH_IDLE;
          else cur_type = b;
        end else if (i == 1) begin
          cur_len = b;
        end else if (i == 2) begin
          cur_handle = {8'h00, b};
        end else if (i == 3) begin
          // Header complete: classify and report it
          cur_handle[15:8] = b;
          eff = (cur_len < 4) ? 4 : cur_len;
          hit = 1'b0;
          seen_hdr = 1'b1;
          last_hdr = hdr_start;
          if (hdr_start + eff > len) begin
            fin = ftsw_pkg::FIN_TRUNC;
            record_end();
          end else if (cur_type < ftsw_pkg::EndTypeByte) begin
            if (!slot_valid[cur_type[6:0]]) begin
              slot_valid[cur_type[6:0]] = 1'b1;
              slot_off[cur_type[6:0]]   = hdr_start;
              slot_ever[cur_type[6:0]]  = 1'b1;
              hit = 1'b1;
            end
          end else if (cur_type == ftsw_pkg::EndTypeByte) begin
            fin = ftsw_pkg::FIN_MARKER;
            record_end();
          end
          if (fin == ftsw_pkg::FIN_NONE) begin
            if (eff == 4) begin
              phase     = ftsw_pkg::PH_STRINGS;
              str_first = 1'b1;
              prev_zero = 1'b0;
            end else begin
              area_end = (hdr_start + eff) & OffMask;
              phase    = ftsw_pkg::PH_FORMATTED;
            end
          end
          r.kind      = ftsw_pkg::KIND_HEADER;
          r.stype     = cur_type;
          r.handle    = cur_handle;
          r.offset    = hdr_start;
          r.flen      = cur_len;
          r.first_hit = hit;
          r.status    = walk_status();
          has = 1'b1;
        end else begin
          phase = ftsw_pkg::PH_IDLE;
        end
      end
      ftsw_pkg::PH_FORMATTED: begin
        if (((pos + 1) & OffMask) == area_end) begin
          phase     = ftsw_pkg::PH_STRINGS;
          str_first = 1'b1;
          prev_zero = 1'b0;
        end
      end
      ftsw_pkg::PH_STRINGS: begin
        if (str_first) begin
          str_first = 1'b0;
          if (b == 8'h00) phase = ftsw_pkg::PH_PAD;
          else prev_zero = 1'b0;
        end else if (b == 8'h00 && prev_zero) begin
          phase     = ftsw_pkg::PH_HEADER;
          hdr_start = (pos + 1) & OffMask;
        end else begin
          prev_zero = (b == 8'h00);
        end
      end
      ftsw_pkg::PH_PAD: begin
        phase     = ftsw_pkg::PH_HEADER;
        hdr_start = (pos + 1) & OffMask;
      end
      default: ;
    endcase

    if (!has && fin == ftsw_pkg::FIN_NONE && pos + 1 == len) begin
      end_walk(r);
      has = 1'b1;
    end
    byte_pos = (pos + 1) & OffMask;
  endfunction

  // Send one transaction; called at a falling edge, returns at a falling edge
  task automatic push_item(input logic [1:0] op, input logic [7:0] data,
                           input logic [6:0] idx);
    bit has;
    walk_result_t r;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, idx, data};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    walk_step(op, data, idx, has, r);
    if (has) pending_reports.push_back(r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic feed_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[k]) push_item(ftsw_pkg::OP_FEED, bytes[k], 7'($urandom_range(0, 127)));
  endtask

  task automatic lookup_type(input logic [6:0] idx);
    push_item(ftsw_pkg::OP_LOOKUP, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic restart_walk();
    push_item(ftsw_pkg::OP_RESTART, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  // Let every outstanding result arrive, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write table_length while idle and read it back
  task automatic set_table_length(input logic [23:0] value);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= TableLengthAddr;
    pwdata  <= {8'h00, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tbl_len = value;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[23:0] !== value) report_mismatch("table_length readback", prdata[23:0], value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [6:0] pick_known_type(output bit ok);
    logic [6:0] known[$];
    for (int k = 0; k < ftsw_pkg::TypeSlots; k++) if (slot_ever[k]) known.push_back(7'(k));
    ok = (known.size() != 0);
    return ok ? known[$urandom_range(0, known.size() - 1)] : '0;
  endfunction

  // Build a well-formed table image of a few structures with random content
  task automatic build_table();
    int unsigned nstruct;
    int unsigned r;
    int unsigned eff;
    int unsigned nstr;
    logic [7:0] typ;
    logic [7:0] flen;
    logic [15:0] hnd;
    table_image.delete();
    nstruct = $urandom_range(1, 5);
    for (int s = 0; s < nstruct; s++) begin
      r = $urandom_range(0, 99);
      if (s == nstruct - 1 && $urandom_range(0, 1)) typ = ftsw_pkg::EndTypeByte;
      else if (r < 50) typ = 8'($urandom_range(0, 7));
      else if (r < 80) typ = 8'($urandom_range(0, 126));
      else if (r < 95) typ = 8'($urandom_range(128, 255));
      else typ = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 15) flen = 8'($urandom_range(0, 3));
      else if (r < 95) flen = 8'($urandom_range(4, 16));
      else if (r < 98) flen = 8'($urandom_range(17, 64));
      else flen = 8'hFF;
      hnd = 16'($urandom_range(0, 65535));
      table_image.push_back(typ);
      table_image.push_back(flen);
      table_image.push_back(hnd[7:0]);
      table_image.push_back(hnd[15:8]);
      eff = (flen < 4) ? 4 : flen;
      repeat (eff - 4) table_image.push_back(8'($urandom_range(0, 255)));
      // String area: either empty (zero plus one byte) or strings ending in a double zero
      nstr = $urandom_range(0, 2);
      if (nstr == 0) begin
        table_image.push_back(8'h00);
        table_image.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat (nstr) begin
          repeat ($urandom_range(1, 4)) table_image.push_back(8'($urandom_range(1, 255)));
          table_image.push_back(8'h00);
        end
        table_image.push_back(8'h00);
      end
    end
  endtask

  // Reset-default length of one byte: no structures, reserved operation ignored
  task automatic test_single_byte_table();
    feed_bytes('{8'h00});
    push_item(OpReserved, 8'hA5, 7'h5A);
    restart_walk();
  endtask

  // Zero length ends the walk on the first byte; later bytes are ignored
  task automatic test_zero_length();
    set_table_length('0);
    feed_bytes('{8'hFF, 8'h00});
    restart_walk();
  endtask

  // Short length, empty string area, type above the end type, end marker
  task automatic test_directed_walk();
    set_table_length(MaxTableLength);
    feed_bytes('{8'h00, 8'h02, 8'h34, 8'h12, 8'h00, 8'hFF,
                 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h41, 8'h00, 8'h00,
                 8'h7F, 8'h04, 8'hCD, 8'hAB});
    lookup_type(ftsw_pkg::EndType);
    restart_walk();
    lookup_type(7'd0);
  endtask

  // Length byte running past the table end truncates the walk
  task automatic test_truncated_header();
    set_table_length(24'd8);
    feed_bytes('{8'h01, 8'hFF, 8'h00, 8'h00});
    lookup_type(ftsw_pkg::EndType);
  endtask

  // Random tables with interleaved lookups, noise and length changes
  task automatic test_random_walks(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned quota);
    int unsigned start;
    int unsigned n;
    int unsigned len;
    int unsigned feed_cnt;
    int unsigned mode;
    int unsigned r;
    int cut;
    bit ok;
    logic [6:0] ti;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < quota) begin
      build_table();
      n = table_image.size();
      mode = $urandom_range(0, 99);
      cut = -1;
      if (mode < 55) begin
        len = n;
        feed_cnt = n;
      end else if (mode < 70) begin
        len = n + $urandom_range(1, 6);
        feed_cnt = len;
      end else if (mode < 85) begin
        len = $urandom_range(1, n);
        feed_cnt = len + $urandom_range(0, 1);
      end else if (mode < 93) begin
        len = MaxTableLength;
        feed_cnt = n;
      end else begin
        len = n;
        feed_cnt = n;
        cut = $urandom_range(2, n - 2);
      end
      while (table_image.size() < feed_cnt) table_image.push_back(8'($urandom_range(0, 255)));
      // Break the sequence now and then
      if ($urandom_range(0, 99) < 15)
        table_image[$urandom_range(0, feed_cnt - 1)] = 8'($urandom_range(0, 255));

      set_table_length(24'(len));
      restart_walk();
      for (int k = 0; k < feed_cnt; k++) begin
        if (k == cut) set_table_length(24'($urandom_range(0, k + 2)));
        r = $urandom_range(0, 99);
        if (r < 8) begin
          ti = pick_known_type(ok);
          if (ok) lookup_type(ti);
        end else if (r == 8) begin
          push_item(OpReserved, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        end else if (r == 9) begin
          restart_walk();
        end
        push_item(ftsw_pkg::OP_FEED, table_image[k], 7'($urandom_range(0, 127)));
      end
    end
  endtask

  // Result side stalls
  always @(negedge clk_i) begin
    m_axis_tready <= (snk_stall_pct == 0) || ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Compare each result transaction with the oldest pending report
  always @(posedge clk_i) begin : result_check
    walk_result_t got;
    walk_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind      = ftsw_pkg::kind_e'(m_axis_tuser);
      got.stype     = m_axis_tdata[7:0];
      got.handle    = m_axis_tdata[23:8];
      got.offset    = m_axis_tdata[47:24];
      got.flen      = m_axis_tdata[55:48];
      got.first_hit = m_axis_tdata[56];
      got.found     = m_axis_tdata[57];
      got.status    = ftsw_pkg::status_e'(m_axis_tdata[60:58]);
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing pending, kind", got.kind, 0);
      end else begin
        want = pending_reports.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.stype !== want.stype) report_mismatch("struct_type", got.stype, want.stype);
        if (got.handle !== want.handle)
          report_mismatch("struct_handle", got.handle, want.handle);
        if (got.offset !== want.offset)
          report_mismatch("struct_offset", got.offset, want.offset);
        if (got.flen !== want.flen) report_mismatch("formatted_length", got.flen, want.flen);
        if (got.first_hit !== want.first_hit)
          report_mismatch("first_of_type", got.first_hit, want.first_hit);
        if (got.found !== want.found) report_mismatch("entry_found", got.found, want.found);
        if (got.status !== want.status)
          report_mismatch("parse_status", got.status, want.status);
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("** firmware_table_structure_walker: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    items_sent     = 0;
    mismatch_count = 0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    idle_cycles    = 0;
    tbl_len        = 24'd1;
    clear_walk();
    for (int k = 0; k < ftsw_pkg::TypeSlots; k++) slot_ever[k] = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_single_byte_table();
    test_zero_length();
    test_directed_walk();
    test_truncated_header();
    test_random_walks(0, 0, 200);
    test_random_walks(49, 0, 200);
    test_random_walks(0, 49, 200);
    test_random_walks(22, 22, 200);

    drain();
    if (mismatch_count == 0) begin
      $display("** firmware_table_structure_walker: PASSED **");
    end else begin
      $display("** firmware_table_structure_walker: FAILED **");
    end
    $finish;
  end

endmodule

// File: firmware_table_structure_walker.f
hw/rtl/ftsw_pkg.sv
hw/rtl/ftsw_ram.sv
hw/rtl/ftsw_queue.sv
hw/rtl/ftsw_front.sv
hw/rtl/ftsw_back.sv
hw/rtl/firmware_table_structure_walker.sv
test/tb.sv
